[rtl/regex_token_stream_builder_unit_assert.svh]
// Assertion macros used by the checker file of this block.
`ifndef REGEX_TOKEN_STREAM_BUILDER_UNIT_ASSERT_SVH
`define REGEX_TOKEN_STREAM_BUILDER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define RGXTOK_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define RGXTOK_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rgxtok_pkg.sv]
`timescale 1ns / 1ps

package rgxtok_pkg;

  localparam int unsigned POSITION_BITS_DEF = 16;
  localparam int unsigned MAX_TOKENS        = 4;
  localparam int unsigned TOK_IDX_W         = $clog2(MAX_TOKENS);
  localparam int unsigned TOK_CNT_W         = $clog2(MAX_TOKENS + 1);
  localparam int unsigned FIFO_DEPTH        = 4;
  localparam int unsigned TDATA_W           = 48;
  localparam int unsigned EPOS_W            = 16;

  typedef enum logic [2:0] {
    KIND_OP    = 3'd0,
    KIND_CAT   = 3'd1,
    KIND_PIECE = 3'd2,
    KIND_END   = 3'd3,
    KIND_ERR   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ERR_RANGE   = 2'd0,
    ERR_BRACKET = 2'd1,
    ERR_STRING  = 2'd2,
    ERR_ESCAPE  = 2'd3
  } errk_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         op;
    logic [7:0]         lo;
    logic [7:0]         hi;
    logic               first;
    logic               last;
    logic               empty;
    errk_t              ek;
    logic [EPOS_W-1:0]  epos;
  } tok_t;

  typedef struct packed {
    logic [TOK_CNT_W-1:0]        cnt;
    tok_t [MAX_TOKENS-1:0]       tok;
  } bundle_t;

endpackage

[rtl/rgxtok_front.sv]
`timescale 1ns / 1ps

module rgxtok_front #(
  parameter int unsigned POSITION_BITS = rgxtok_pkg::POSITION_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_valid,
  output logic                s_ready,
  input  logic [7:0]          s_byte,
  input  logic                s_final,
  output logic                push_valid,
  input  logic                push_ready,
  output rgxtok_pkg::bundle_t push_data
);

  localparam logic [7:0] CH_AMP      = 8'h26;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_DASH     = 8'h2D;
  localparam logic [7:0] CH_N        = 8'h6E;
  localparam logic [7:0] CH_T        = 8'h74;
  localparam logic [7:0] CH_R        = 8'h72;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_LPAREN   = 8'h28;
  localparam logic [7:0] CH_RPAREN   = 8'h29;
  localparam logic [7:0] CH_STAR     = 8'h2A;
  localparam logic [7:0] CH_PIPE     = 8'h7C;
  localparam logic [7:0] CH_QMARK    = 8'h3F;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;

  typedef enum logic [3:0] {
    MODE_PLAIN  = 4'b0001,
    MODE_CLASS  = 4'b0010,
    MODE_QUOTE  = 4'b0100,
    MODE_ESCAPE = 4'b1000
  } mode_t;

  typedef enum logic [1:0] {
    PREV_NONE    = 2'd0,
    PREV_OPERAND = 2'd1,
    PREV_SUFFIX  = 2'd2,
    PREV_OPEN    = 2'd3
  } prev_t;

  function automatic logic [7:0] unescape(input logic [7:0] ch);
    logic [7:0] r;
    r = ch;
    if (ch == CH_N) r = 8'd10;
    else if (ch == CH_T) r = 8'd9;
    else if (ch == CH_R) r = 8'd13;
    else if (ch == CH_ZERO) r = 8'd0;
    return r;
  endfunction

  function automatic rgxtok_pkg::tok_t mk_op(input rgxtok_pkg::kind_t kind,
                                             input logic [7:0] ch);
    rgxtok_pkg::tok_t t;
    t = '0;
    t.kind = kind;
    t.op = ch;
    return t;
  endfunction

  function automatic rgxtok_pkg::tok_t mk_piece(input logic [7:0] lo, input logic [7:0] hi,
                                                input logic first, input logic last,
                                                input logic empty);
    rgxtok_pkg::tok_t t;
    t = '0;
    t.kind = rgxtok_pkg::KIND_PIECE;
    t.lo = lo;
    t.hi = hi;
    t.first = first;
    t.last = last;
    t.empty = empty;
    return t;
  endfunction

  mode_t                    mode, mode_next;
  prev_t                    prev, prev_next;
  logic [7:0]               w0, w0_next, w1, w1_next;
  logic [1:0]               wcnt, wcnt_next;
  logic                     sent, sent_next;
  logic                     bad, bad_next;
  logic                     err, err_next;
  logic [POSITION_BITS-1:0] pos, pos_next;
  logic [POSITION_BITS-1:0] open_pos, open_pos_next;

  logic                     accept;
  logic                     pa_req, pa_cls, pa_last, pa_empty, pa_first, pb_req, pb_first;
  logic [7:0]               pa_lo, pa_hi;
  logic                     op_req, er_req;
  rgxtok_pkg::errk_t        er_kind;
  logic [POSITION_BITS-1:0] er_pos;
  logic [rgxtok_pkg::TOK_CNT_W-1:0] n;
  rgxtok_pkg::bundle_t      bundle;

  assign s_ready    = push_ready;
  assign accept     = s_valid && push_ready;
  assign push_valid = accept && (bundle.cnt != '0);
  assign push_data  = bundle;

  always_comb begin
    mode_next     = mode;
    prev_next     = prev;
    w0_next       = w0;
    w1_next       = w1;
    wcnt_next     = wcnt;
    sent_next     = sent;
    bad_next      = bad;
    err_next      = err;
    pos_next      = pos + 1'b1;
    open_pos_next = open_pos;
    pa_req        = 1'b0;
    pa_cls        = 1'b0;
    pa_lo         = s_byte;
    pa_hi         = s_byte;
    pa_last       = 1'b1;
    pa_empty      = 1'b0;
    pa_first      = 1'b1;
    pb_req        = 1'b0;
    pb_first      = 1'b0;
    op_req        = 1'b0;
    er_req        = 1'b0;
    er_kind       = rgxtok_pkg::ERR_RANGE;
    er_pos        = open_pos;
    bundle        = '0;
    n             = '0;
    if (!err) begin
      case (mode)
        MODE_PLAIN: begin
          if (s_byte == CH_LBRACKET) begin
            mode_next     = MODE_CLASS;
            open_pos_next = pos;
            wcnt_next     = 2'd0;
            sent_next     = 1'b0;
            bad_next      = 1'b0;
            if (s_final) begin
              er_req  = 1'b1;
              er_kind = rgxtok_pkg::ERR_BRACKET;
              er_pos  = pos;
            end
          end else if (s_byte == CH_QUOTE) begin
            mode_next     = MODE_QUOTE;
            open_pos_next = pos;
            if (s_final) begin
              er_req  = 1'b1;
              er_kind = rgxtok_pkg::ERR_STRING;
              er_pos  = pos;
            end
          end else if (s_byte inside {CH_LPAREN, CH_RPAREN, CH_STAR, CH_PIPE,
                                      CH_QMARK, CH_PLUS}) begin
            op_req = 1'b1;
          end else begin
            pa_req = 1'b1;
          end
        end
        MODE_CLASS: begin
          if (s_byte == CH_RBRACKET) begin
            mode_next = MODE_PLAIN;
            if (bad) begin
              er_req  = 1'b1;
              er_kind = rgxtok_pkg::ERR_RANGE;
            end else begin
              pa_cls = 1'b1;
              case (wcnt)
                2'd0: begin
                  pa_req   = !sent;
                  pa_lo    = 8'd0;
                  pa_hi    = 8'd0;
                  pa_empty = 1'b1;
                end
                2'd1: begin
                  pa_req = 1'b1;
                  pa_lo  = w0;
                  pa_hi  = w0;
                end
                2'd2: begin
                  pa_req  = 1'b1;
                  pa_lo   = w0;
                  pa_hi   = w0;
                  pa_last = 1'b0;
                  pb_req  = 1'b1;
                end
                default: begin
                  pa_req = 1'b1;
                  pa_lo  = w0;
                  pa_hi  = w1;
                end
              endcase
            end
          end else if (s_final) begin
            er_req  = 1'b1;
            er_kind = rgxtok_pkg::ERR_BRACKET;
          end else begin
            pa_cls  = 1'b1;
            pa_last = 1'b0;
            case (wcnt)
              2'd0: begin
                w0_next   = s_byte;
                wcnt_next = 2'd1;
              end
              2'd1: begin
                w1_next   = s_byte;
                wcnt_next = 2'd2;
              end
              2'd2: begin
                if (w1 == CH_DASH) begin
                  if (w0 > s_byte) bad_next = 1'b1;
                  w1_next   = s_byte;
                  wcnt_next = 2'd3;
                end else begin
                  pa_req  = 1'b1;
                  pa_lo   = w0;
                  pa_hi   = w0;
                  w0_next = w1;
                  w1_next = s_byte;
                end
              end
              default: begin
                pa_req    = 1'b1;
                pa_lo     = w0;
                pa_hi     = w1;
                w0_next   = s_byte;
                wcnt_next = 2'd1;
              end
            endcase
          end
        end
        MODE_QUOTE: begin
          if (s_byte == CH_QUOTE) begin
            mode_next = MODE_PLAIN;
          end else if (s_byte == CH_BSLASH) begin
            mode_next = MODE_ESCAPE;
            if (s_final) begin
              er_req  = 1'b1;
              er_kind = rgxtok_pkg::ERR_ESCAPE;
            end
          end else begin
            pa_req = 1'b1;
            if (s_final) begin
              er_req  = 1'b1;
              er_kind = rgxtok_pkg::ERR_STRING;
            end
          end
        end
        MODE_ESCAPE: begin
          pa_req    = 1'b1;
          pa_lo     = unescape(s_byte);
          pa_hi     = unescape(s_byte);
          mode_next = MODE_QUOTE;
          if (s_final) begin
            er_req  = 1'b1;
            er_kind = rgxtok_pkg::ERR_STRING;
          end
        end
        default: begin
          mode_next = MODE_PLAIN;
        end
      endcase

      if (op_req) begin
        if (s_byte == CH_LPAREN && (prev_next == PREV_OPERAND || prev_next == PREV_SUFFIX)) begin
          bundle.tok[n[rgxtok_pkg::TOK_IDX_W-1:0]] = mk_op(rgxtok_pkg::KIND_CAT, CH_AMP);
          n = n + 1'b1;
        end
        bundle.tok[n[rgxtok_pkg::TOK_IDX_W-1:0]] = mk_op(rgxtok_pkg::KIND_OP, s_byte);
        n = n + 1'b1;
        prev_next = (s_byte == CH_LPAREN || s_byte == CH_PIPE) ? PREV_OPEN : PREV_SUFFIX;
      end

      if (pa_req && !(pa_cls && bad_next)) begin
        pa_first = pa_cls ? !sent_next : 1'b1;
        if (pa_first && (prev_next == PREV_OPERAND || prev_next == PREV_SUFFIX)) begin
          bundle.tok[n[rgxtok_pkg::TOK_IDX_W-1:0]] = mk_op(rgxtok_pkg::KIND_CAT, CH_AMP);
          n = n + 1'b1;
        end
        bundle.tok[n[rgxtok_pkg::TOK_IDX_W-1:0]] =
          mk_piece(pa_lo, pa_hi, pa_first, pa_last, pa_empty);
        n = n + 1'b1;
        if (pa_last) prev_next = PREV_OPERAND;
        if (pa_cls) sent_next = 1'b1;
      end

      if (pb_req && !bad_next) begin
        pb_first = !sent_next;
        if (pb_first && (prev_next == PREV_OPERAND || prev_next == PREV_SUFFIX)) begin
          bundle.tok[n[rgxtok_pkg::TOK_IDX_W-1:0]] = mk_op(rgxtok_pkg::KIND_CAT, CH_AMP);
          n = n + 1'b1;
        end
        bundle.tok[n[rgxtok_pkg::TOK_IDX_W-1:0]] = mk_piece(w1, w1, pb_first, 1'b1, 1'b0);
        n = n + 1'b1;
        prev_next = PREV_OPERAND;
        sent_next = 1'b1;
      end

      if (er_req) begin
        bundle.tok[n[rgxtok_pkg::TOK_IDX_W-1:0]]      = '0;
        bundle.tok[n[rgxtok_pkg::TOK_IDX_W-1:0]].kind = rgxtok_pkg::KIND_ERR;
        bundle.tok[n[rgxtok_pkg::TOK_IDX_W-1:0]].ek   = er_kind;
        bundle.tok[n[rgxtok_pkg::TOK_IDX_W-1:0]].epos = rgxtok_pkg::EPOS_W'(er_pos);
        n = n + 1'b1;
        err_next = 1'b1;
      end else if (s_final) begin
        bundle.tok[n[rgxtok_pkg::TOK_IDX_W-1:0]] = mk_op(rgxtok_pkg::KIND_END, 8'd0);
        n = n + 1'b1;
      end
    end
    bundle.cnt = n;

    if (s_final) begin
      mode_next     = MODE_PLAIN;
      prev_next     = PREV_NONE;
      wcnt_next     = 2'd0;
      sent_next     = 1'b0;
      bad_next      = 1'b0;
      err_next      = 1'b0;
      pos_next      = '0;
      open_pos_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_PLAIN;
      prev     <= PREV_NONE;
      wcnt     <= 2'd0;
      sent     <= 1'b0;
      bad      <= 1'b0;
      err      <= 1'b0;
      pos      <= '0;
      open_pos <= '0;
    end else if (accept) begin
      mode     <= mode_next;
      prev     <= prev_next;
      wcnt     <= wcnt_next;
      sent     <= sent_next;
      bad      <= bad_next;
      err      <= err_next;
      pos      <= pos_next;
      open_pos <= open_pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      w0 <= w0_next;
      w1 <= w1_next;
    end
  end

endmodule

[rtl/rgxtok_fifo.sv]
`timescale 1ns / 1ps

module rgxtok_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  rgxtok_pkg::bundle_t push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output rgxtok_pkg::bundle_t pop_data
);

  localparam int unsigned DEPTH = rgxtok_pkg::FIFO_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  rgxtok_pkg::bundle_t mem [DEPTH];
  logic [PTR_W-1:0]    wr_ptr, rd_ptr;
  logic [CNT_W-1:0]    count;
  logic                do_push, do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

endmodule

[rtl/rgxtok_back.sv]
`timescale 1ns / 1ps

module rgxtok_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pop_valid,
  output logic                          pop_ready,
  input  rgxtok_pkg::bundle_t           pop_data,
  output logic                          m_valid,
  input  logic                          m_ready,
  output logic [rgxtok_pkg::TDATA_W-1:0] m_data,
  output rgxtok_pkg::kind_t             m_kind,
  output logic                          m_last
);

  rgxtok_pkg::bundle_t              cur;
  logic                             cur_valid;
  logic [rgxtok_pkg::TOK_IDX_W-1:0] idx;
  rgxtok_pkg::tok_t                 t;
  logic                             at_end, take;

  assign t       = cur.tok[idx];
  assign at_end  = ({1'b0, idx} + 1'b1) == cur.cnt;
  assign take    = !cur_valid || (m_ready && at_end);
  assign pop_ready = take;

  assign m_valid = cur_valid;
  assign m_kind  = t.kind;
  assign m_last  = t.last;
  assign m_data  = {4'b0000, t.epos, t.ek, t.empty, t.first, t.hi, t.lo, t.op};

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (take) begin
      cur_valid <= pop_valid;
      idx       <= '0;
    end else if (m_ready) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && pop_valid) cur <= pop_data;
  end

endmodule

[rtl/regex_token_stream_builder_unit.sv]
`timescale 1ns / 1ps
// Regular-expression tokenizer that inserts the implied concat operator.
// The slave stream carries one pattern byte per request in s_axis_tdata, with
// s_axis_tlast set on the byte that ends the pattern. The master stream carries
// one token per request: the token kind in m_axis_tuser and the last-piece mark
// in m_axis_tlast.
// A byte is accepted in every cycle while the token queue has room, so the input
// sustains one byte per cycle. The output delivers one token per cycle while
// m_axis_tready is high; a byte that yields up to four tokens (a concat, two
// class pieces and the end token) has them sent one after another, and the
// four-entry queue between the scanner and the output stage absorbs such bursts.
// The tokens of a byte are written into the queue when the byte is accepted and
// are offered once the output stage has loaded them from the queue.
// Reset clears the scanner, the queue and the output stage; no token is pending
// afterward and s_axis_tready is high.
// When the receiver holds m_axis_tready low the current token stays on the port,
// the queue fills, and s_axis_tready drops once it is full.

module regex_token_stream_builder_unit #(
  parameter int unsigned POSITION_BITS = rgxtok_pkg::POSITION_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // pattern_byte[7:0]
  input  logic [7:0]                     s_axis_tdata,
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // operator_char[7:0], range_low[15:8], range_high[23:16], piece_first[24],
  // piece_empty[25], error_kind[27:26], error_position[43:28], zero[47:44]
  output logic [rgxtok_pkg::TDATA_W-1:0] m_axis_tdata,
  // token_kind[2:0]
  output logic [2:0]                     m_axis_tuser,
  output logic                           m_axis_tlast
);

  logic                push_valid, push_ready, pop_valid, pop_ready;
  rgxtok_pkg::bundle_t push_data, pop_data;
  rgxtok_pkg::kind_t   m_kind;

  assign m_axis_tuser = m_kind;

  rgxtok_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_valid   (s_axis_tvalid),
    .s_ready   (s_axis_tready),
    .s_byte    (s_axis_tdata),
    .s_final   (s_axis_tlast),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data)
  );

  rgxtok_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  rgxtok_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_data (pop_data),
    .m_valid  (m_axis_tvalid),
    .m_ready  (m_axis_tready),
    .m_data   (m_axis_tdata),
    .m_kind   (m_kind),
    .m_last   (m_axis_tlast)
  );

endmodule

[rtl/rgxtok_checker.sv]
`timescale 1ns / 1ps
`include "regex_token_stream_builder_unit_assert.svh"

module rgxtok_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [rgxtok_pkg::TDATA_W-1:0] m_axis_tdata,
  input logic [2:0]                     m_axis_tuser,
  input logic                           m_axis_tlast
);

  `RGXTOK_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled token changed")
  `RGXTOK_ASSERT_NXT(a_reset_clear, rst, !m_axis_tvalid && s_axis_tready, "tokens pending after reset")
  `RGXTOK_ASSERT_IMP(a_full_has_out, !s_axis_tready, m_axis_tvalid, "queue full with no token offered")
  `RGXTOK_ASSERT_IMP(a_kind_legal, m_axis_tvalid, m_axis_tuser <= rgxtok_pkg::KIND_ERR, "illegal token kind")
  `RGXTOK_ASSERT_IMP(a_nonpiece_clean, m_axis_tvalid && (m_axis_tuser != rgxtok_pkg::KIND_PIECE), !m_axis_tlast && (m_axis_tdata[25:8] == '0), "piece fields set on a non-piece token")

endmodule

bind regex_token_stream_builder_unit rgxtok_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  typedef enum logic [1:0] {
    SCAN_PLAIN  = 2'd0,
    SCAN_CLASS  = 2'd1,
    SCAN_QUOTE  = 2'd2,
    SCAN_ESCAPE = 2'd3
  } scan_t;

  typedef enum logic [1:0] {
    PREV_NONE    = 2'd0,
    PREV_OPERAND = 2'd1,
    PREV_SUFFIX  = 2'd2,
    PREV_OPEN    = 2'd3
  } prev_t;

  localparam logic [7:0] CH_AMP    = "&";
  localparam logic [7:0] CH_LBRACK = "[";
  localparam logic [7:0] CH_RBRACK = "]";
  localparam logic [7:0] CH_DASH   = "-";
  localparam logic [7:0] CH_LPAREN = "(";
  localparam logic [7:0] CH_RPAREN = ")";
  localparam logic [7:0] CH_STAR   = "*";
  localparam logic [7:0] CH_BAR    = "|";
  localparam logic [7:0] CH_QMARK  = "?";
  localparam logic [7:0] CH_PLUS   = "+";
  localparam logic [7:0] CH_QUOTE  = "\"";
  localparam logic [7:0] CH_BSLASH = "\\";
  localparam logic [7:0] CH_N      = "n";
  localparam logic [7:0] CH_T      = "t";
  localparam logic [7:0] CH_R      = "r";
  localparam logic [7:0] CH_ZERO   = "0";
  localparam int RANDOM_PER_PHASE  = 140;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [7:0]                        s_axis_tdata = 8'd0;
  logic                              s_axis_tlast = 1'b0;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [rgxtok_pkg::TDATA_W-1:0]    m_axis_tdata;
  logic [2:0]                        m_axis_tuser;
  logic                              m_axis_tlast;

  regex_token_stream_builder_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  int src_idle_pct = 0;
  int dst_idle_pct = 0;
  int fail_count   = 0;
  int live_bytes   = 0;
  int burst_len    = 0;

  rgxtok_pkg::tok_t expected_tokens[$];
  logic [7:0]       pattern_buf[$];

  scan_t       scan_mode;
  prev_t       prev_class;
  logic [7:0]  win_lo;
  logic [7:0]  win_hi;
  int          win_cnt;
  logic        pieces_sent;
  logic        class_bad;
  logic        err_latched;
  logic [15:0] byte_pos;
  logic [15:0] open_pos;

  function automatic void clear_scanner();
    scan_mode   = SCAN_PLAIN;
    prev_class  = PREV_NONE;
    win_lo      = 8'd0;
    win_hi      = 8'd0;
    win_cnt     = 0;
    pieces_sent = 1'b0;
    class_bad   = 1'b0;
    err_latched = 1'b0;
    byte_pos    = 16'd0;
    open_pos    = 16'd0;
  endfunction

  function automatic void push_token(rgxtok_pkg::kind_t k, logic [7:0] op, logic [7:0] lo,
                                     logic [7:0] hi, logic is_first, logic is_last,
                                     logic is_empty, rgxtok_pkg::errk_t ek,
                                     logic [15:0] epos);
    rgxtok_pkg::tok_t t;
    if (burst_len >= rgxtok_pkg::MAX_TOKENS) return;
    t.kind  = k;
    t.op    = op;
    t.lo    = lo;
    t.hi    = hi;
    t.first = is_first;
    t.last  = is_last;
    t.empty = is_empty;
    t.ek    = ek;
    t.epos  = epos;
    expected_tokens.insert(expected_tokens.size(), t);
    burst_len++;
  endfunction

  function automatic void push_error(rgxtok_pkg::errk_t ek, logic [15:0] epos);
    push_token(rgxtok_pkg::KIND_ERR, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, ek, epos);
    err_latched = 1'b1;
  endfunction

  function automatic void push_concat();
    push_token(rgxtok_pkg::KIND_CAT, CH_AMP, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0,
               rgxtok_pkg::ERR_RANGE, 16'd0);
  endfunction

  function automatic void push_piece(logic [7:0] lo, logic [7:0] hi, logic is_first,
                                     logic is_last, logic is_empty);
    if (is_first && (prev_class == PREV_OPERAND || prev_class == PREV_SUFFIX))
      push_concat();
    push_token(rgxtok_pkg::KIND_PIECE, 8'd0, lo, hi, is_first, is_last, is_empty,
               rgxtok_pkg::ERR_RANGE, 16'd0);
    if (is_last)
      prev_class = PREV_OPERAND;
  endfunction

  function automatic void push_class_piece(logic [7:0] lo, logic [7:0] hi, logic is_last);
    if (class_bad) return;
    push_piece(lo, hi, !pieces_sent, is_last, 1'b0);
    pieces_sent = 1'b1;
  endfunction

  function automatic void class_byte(logic [7:0] c);
    case (win_cnt)
      0: begin
        win_lo  = c;
        win_cnt = 1;
      end
      1: begin
        win_hi  = c;
        win_cnt = 2;
      end
      2: begin
        if (win_hi == CH_DASH) begin
          if (win_lo > c)
            class_bad = 1'b1;
          win_hi  = c;
          win_cnt = 3;
        end else begin
          push_class_piece(win_lo, win_lo, 1'b0);
          win_lo = win_hi;
          win_hi = c;
        end
      end
      default: begin
        push_class_piece(win_lo, win_hi, 1'b0);
        win_lo  = c;
        win_cnt = 1;
      end
    endcase
  endfunction

  function automatic void class_close();
    if (class_bad) begin
      push_error(rgxtok_pkg::ERR_RANGE, open_pos);
    end else if (win_cnt == 0) begin
      if (!pieces_sent)
        push_piece(8'd0, 8'd0, 1'b1, 1'b1, 1'b1);
    end else if (win_cnt == 1) begin
      push_class_piece(win_lo, win_lo, 1'b1);
    end else if (win_cnt == 2) begin
      push_class_piece(win_lo, win_lo, 1'b0);
      push_class_piece(win_hi, win_hi, 1'b1);
    end else begin
      push_class_piece(win_lo, win_hi, 1'b1);
    end
    scan_mode = SCAN_PLAIN;
  endfunction

  function automatic logic [7:0] unescape(logic [7:0] c);
    if (c == CH_N) return 8'd10;
    if (c == CH_T) return 8'd9;
    if (c == CH_R) return 8'd13;
    if (c == CH_ZERO) return 8'd0;
    return c;
  endfunction

  function automatic void predict_tokens(logic [7:0] c, logic fin);
    logic [7:0] e;
    burst_len = 0;
    if (!err_latched) begin
      case (scan_mode)
        SCAN_PLAIN: begin
          if (c == CH_LBRACK) begin
            scan_mode   = SCAN_CLASS;
            open_pos    = byte_pos;
            win_cnt     = 0;
            pieces_sent = 1'b0;
            class_bad   = 1'b0;
            if (fin)
              push_error(rgxtok_pkg::ERR_BRACKET, byte_pos);
          end else if (c == CH_QUOTE) begin
            scan_mode = SCAN_QUOTE;
            open_pos  = byte_pos;
            if (fin)
              push_error(rgxtok_pkg::ERR_STRING, byte_pos);
          end else if (c inside {CH_LPAREN, CH_RPAREN, CH_STAR, CH_BAR, CH_QMARK,
                                 CH_PLUS}) begin
            if (c == CH_LPAREN && (prev_class == PREV_OPERAND || prev_class == PREV_SUFFIX))
              push_concat();
            push_token(rgxtok_pkg::KIND_OP, c, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0,
                       rgxtok_pkg::ERR_RANGE, 16'd0);
            prev_class = (c == CH_LPAREN || c == CH_BAR) ? PREV_OPEN : PREV_SUFFIX;
          end else begin
            push_piece(c, c, 1'b1, 1'b1, 1'b0);
          end
        end
        SCAN_CLASS: begin
          if (c == CH_RBRACK)
            class_close();
          else if (fin)
            push_error(rgxtok_pkg::ERR_BRACKET, open_pos);
          else
            class_byte(c);
        end
        SCAN_QUOTE: begin
          if (c == CH_QUOTE) begin
            scan_mode = SCAN_PLAIN;
          end else if (c == CH_BSLASH) begin
            scan_mode = SCAN_ESCAPE;
            if (fin)
              push_error(rgxtok_pkg::ERR_ESCAPE, open_pos);
          end else begin
            push_piece(c, c, 1'b1, 1'b1, 1'b0);
            if (fin)
              push_error(rgxtok_pkg::ERR_STRING, open_pos);
          end
        end
        default: begin
          e = unescape(c);
          push_piece(e, e, 1'b1, 1'b1, 1'b0);
          scan_mode = SCAN_QUOTE;
          if (fin)
            push_error(rgxtok_pkg::ERR_STRING, open_pos);
        end
      endcase
      if (fin && !err_latched)
        push_token(rgxtok_pkg::KIND_END, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0,
                   rgxtok_pkg::ERR_RANGE, 16'd0);
    end
    if (fin)
      clear_scanner();
    else
      byte_pos = byte_pos + 16'd1;
  endfunction

  function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void check_token();
    rgxtok_pkg::tok_t want;
    if (expected_tokens.size() == 0) begin
      $display("%0t: unexpected token, expected none actual kind %0h data %0h",
               $time, m_axis_tuser, m_axis_tdata);
      fail_count++;
      return;
    end
    want = expected_tokens.pop_front();
    compare_field("token_kind", 16'(want.kind), 16'(m_axis_tuser));
    compare_field("operator_char", 16'(want.op), 16'(m_axis_tdata[7:0]));
    compare_field("range_low", 16'(want.lo), 16'(m_axis_tdata[15:8]));
    compare_field("range_high", 16'(want.hi), 16'(m_axis_tdata[23:16]));
    compare_field("piece_first", 16'(want.first), 16'(m_axis_tdata[24]));
    compare_field("piece_last", 16'(want.last), 16'(m_axis_tlast));
    compare_field("piece_empty", 16'(want.empty), 16'(m_axis_tdata[25]));
    compare_field("error_kind", 16'(want.ek), 16'(m_axis_tdata[27:26]));
    compare_field("error_position", want.epos, m_axis_tdata[43:28]);
    compare_field("tdata_padding", 16'd0, 16'(m_axis_tdata[47:44]));
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready)
        check_token();
      m_axis_tready <= ($urandom_range(99, 0) >= dst_idle_pct);
    end
  end

  task automatic send_byte(logic [7:0] c, logic fin);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= fin;
    do @(posedge clk); while (!s_axis_tready);
    if (!err_latched)
      live_bytes++;
    predict_tokens(c, fin);
  endtask

  task automatic send_text(string s, logic fin_at_end);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], fin_at_end && (i == s.len() - 1));
  endtask

  task automatic send_pattern();
    foreach (pattern_buf[i])
      send_byte(pattern_buf[i], i == pattern_buf.size() - 1);
  endtask

  task automatic pause_sender();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_tokens.size() != 0)
      @(posedge clk);
  endtask

  function automatic void append_byte(logic [7:0] c);
    pattern_buf.insert(pattern_buf.size(), c);
  endfunction

  function automatic logic [7:0] class_char();
    logic [7:0] c;
    c = 8'($urandom_range(255, 0));
    if (c == CH_RBRACK)
      c = CH_DASH;
    return c;
  endfunction

  function automatic void add_class();
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] tmp;
    append_byte(CH_LBRACK);
    repeat ($urandom_range(5, 0)) begin
      case ($urandom_range(3, 0))
        0: append_byte(CH_DASH);
        1: begin
          lo = class_char();
          hi = class_char();
          if (lo > hi && $urandom_range(9, 0) != 0) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
          end
          append_byte(lo);
          append_byte(CH_DASH);
          append_byte(hi);
        end
        default: append_byte(class_char());
      endcase
    end
    append_byte(CH_RBRACK);
  endfunction

  function automatic void add_quote();
    logic [7:0] c;
    append_byte(CH_QUOTE);
    repeat ($urandom_range(4, 0)) begin
      if ($urandom_range(2, 0) == 0) begin
        append_byte(CH_BSLASH);
        case ($urandom_range(5, 0))
          0: c = CH_N;
          1: c = CH_T;
          2: c = CH_R;
          3: c = CH_ZERO;
          default: c = 8'($urandom_range(255, 0));
        endcase
      end else begin
        c = 8'($urandom_range(255, 0));
        if (c == CH_QUOTE || c == CH_BSLASH)
          c = CH_QMARK;
      end
      append_byte(c);
    end
    append_byte(CH_QUOTE);
  endfunction

  function automatic void add_operator();
    case ($urandom_range(5, 0))
      0: append_byte(CH_LPAREN);
      1: append_byte(CH_RPAREN);
      2: append_byte(CH_STAR);
      3: append_byte(CH_BAR);
      4: append_byte(CH_QMARK);
      default: append_byte(CH_PLUS);
    endcase
  endfunction

  function automatic void build_pattern();
    logic [7:0] c;
    int sel;
    int len;
    pattern_buf.delete();
    repeat ($urandom_range(6, 1)) begin
      sel = $urandom_range(99, 0);
      if (sel < 35) begin
        c = 8'($urandom_range(255, 0));
        if (c == CH_LBRACK || c == CH_QUOTE)
          c = CH_AMP;
        append_byte(c);
      end else if (sel < 60) begin
        add_class();
      end else if (sel < 80) begin
        add_quote();
      end else begin
        add_operator();
      end
    end
    sel = $urandom_range(99, 0);
    if (sel >= 90) begin
      pattern_buf.delete();
      repeat ($urandom_range(6, 1))
        append_byte(8'($urandom_range(255, 0)));
    end else if (sel >= 80) begin
      len = $urandom_range(pattern_buf.size(), 1);
      pattern_buf = pattern_buf[0:len-1];
    end
  endfunction

  task automatic test_operators();
    send_text("]()*", 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("|?+", 1'b1);
  endtask

  task automatic test_classes();
    send_text("[-a-c-]", 1'b1);
    send_byte(8'h00, 1'b0);
    send_text("[]", 1'b1);
  endtask

  task automatic test_quotes();
    send_text("\"\\r\\0\"", 1'b1);
  endtask

  task automatic test_errors();
    send_text("[b-a]x", 1'b1);
    send_text("[x", 1'b1);
    send_text("\"\\", 1'b1);
    send_text("\"", 1'b1);
  endtask

  task automatic test_random(int src_pct, int dst_pct);
    int goal;
    src_idle_pct = src_pct;
    dst_idle_pct = dst_pct;
    goal = live_bytes + RANDOM_PER_PHASE;
    while (live_bytes < goal) begin
      build_pattern();
      send_pattern();
    end
    pause_sender();
  endtask

  task automatic test_high_position();
    src_idle_pct = 0;
    dst_idle_pct = 0;
    repeat (4)
      send_text("\"\"", 1'b0);
    send_text("a\"x", 1'b1);
    pause_sender();
  endtask

  initial begin
    clear_scanner();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    src_idle_pct = 38;
    dst_idle_pct = 68;
    test_operators();
    test_classes();
    test_quotes();
    test_errors();
    pause_sender();
    test_random(38, 68);
    test_random(68, 38);
    test_random(0, 0);
    test_high_position();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && expected_tokens.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
